>>> sv/bms_pkg.sv
package bms_pkg;

    // fixed sizes of the search
    localparam int VEC_BITS          = 32;
    localparam int LEVEL_SLOTS       = 8;
    localparam int PATTERN_SLOTS     = 31;
    localparam int MAX_PATTERN_BYTES = 31;

    localparam logic [VEC_BITS-1:0] VECTOR_INIT = ~32'd1;

    // configuration register indexes
    localparam logic [2:0] REG_PAT_0_7   = 3'd0;
    localparam logic [2:0] REG_PAT_8_15  = 3'd1;
    localparam logic [2:0] REG_PAT_16_23 = 3'd2;
    localparam logic [2:0] REG_PAT_24_30 = 3'd3;
    localparam logic [2:0] REG_PAT_LEN   = 3'd4;
    localparam logic [2:0] REG_ERRORS    = 3'd5;

    // search status codes
    localparam logic [1:0] ST_SEARCHING = 2'd0;
    localparam logic [1:0] ST_MATCH_NOW = 2'd1;
    localparam logic [1:0] ST_NO_MATCH  = 2'd2;
    localparam logic [1:0] ST_MATCHED   = 2'd3;

    typedef logic [PATTERN_SLOTS-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  search_status;
        logic [15:0] match_start;
        logic        end_of_text;
    } t_out_item;

endpackage

>>> sv/bitap_mismatch_search_top.sv
// a byte's result is registered at its transfer: into the output register, or into the skid stage while that is stalled
// throughput: one text byte per cycle while o_in_stall is low, all error levels update together in one pass
// a skid stage behind the output register keeps input flowing for one stalled result
// reset (synchronous, active low) clears pattern, length, error count and text state;
// the level vectors come back all ones except bit zero
module bitap_mismatch_search_top
    import bms_pkg::*;
#(
    parameter int MAX_ERROR_LEVELS = 7,
    parameter int POSITION_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);

    logic [63:0] r_pat0, r_pat1, r_pat2;
    logic [55:0] r_pat3;
    logic [4:0]  r_len;
    logic [2:0]  r_errors;

    t_pattern    pattern;
    t_out_item   result;
    t_out_item   r_out, r_skid;
    logic        r_out_valid, r_skid_valid;
    logic        accept, out_taken;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat0   <= '0;
            r_pat1   <= '0;
            r_pat2   <= '0;
            r_pat3   <= '0;
            r_len    <= '0;
            r_errors <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAT_0_7:   r_pat0   <= i_cfg_data;
                REG_PAT_8_15:  r_pat1   <= i_cfg_data;
                REG_PAT_16_23: r_pat2   <= i_cfg_data;
                REG_PAT_24_30: r_pat3   <= i_cfg_data[55:0];
                REG_PAT_LEN:   r_len    <= i_cfg_data[4:0];
                REG_ERRORS:    r_errors <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign pattern = {r_pat3, r_pat2, r_pat1, r_pat0};

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_taken  = r_out_valid && !i_out_stall;

    bms_core #(
        .MAX_ERROR_LEVELS (MAX_ERROR_LEVELS),
        .POSITION_BITS    (POSITION_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .i_pattern (pattern),
        .i_length  (r_len),
        .i_errors  (r_errors),
        .o_result  (result)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_taken) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                if (!r_out_valid || out_taken) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_taken) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || out_taken) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> sv/bms_mask.sv
module bms_mask
    import bms_pkg::*;
(
    input  t_pattern              i_pattern,
    input  logic [4:0]            i_length,
    input  logic [7:0]            i_byte,
    output logic [VEC_BITS-1:0]   o_mask
);

    // bit i clear where pattern byte i is in use and equals the text byte
    always_comb begin
        o_mask = '1;
        for (int i = 0; i < PATTERN_SLOTS; i++) begin
            if ((5'(i) < i_length) && (i_pattern[i] == i_byte)) begin
                o_mask[i] = 1'b0;
            end
        end
    end

endmodule

>>> sv/bms_core.sv
module bms_core
    import bms_pkg::*;
#(
    parameter int MAX_ERROR_LEVELS = 7,
    parameter int POSITION_BITS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_item   i_item,
    input  t_pattern   i_pattern,
    input  logic [4:0] i_length,
    input  logic [2:0] i_errors,
    output t_out_item  o_result
);

    localparam int LEVELS = (MAX_ERROR_LEVELS < LEVEL_SLOTS - 1) ?
                            MAX_ERROR_LEVELS + 1 : LEVEL_SLOTS;
    localparam int KMAX   = LEVELS - 1;
    localparam int PW     = POSITION_BITS;
    localparam int SW     = (PW + 1 > 16) ? PW + 1 : 16;

    logic [LEVELS-1:0][VEC_BITS-1:0] r_lv, n_lv, upd_lv;
    logic [PW-1:0]                   r_pos, n_pos;
    logic                            r_seen, n_seen;

    logic [VEC_BITS-1:0] mask;
    logic [2:0]          k_eff;
    logic                hit;
    logic [PW:0]         pos_inc;
    logic [SW-1:0]       start_w;

    bms_mask u_mask (
        .i_pattern (i_pattern),
        .i_length  (i_length),
        .i_byte    (i_item.text_byte),
        .o_mask    (mask)
    );

    // error count limited to the levels that exist
    assign k_eff = (32'(i_errors) > KMAX) ? 3'(KMAX) : i_errors;

    // shift-or update, only levels up to k move
    always_comb begin
        upd_lv    = r_lv;
        upd_lv[0] = (r_lv[0] | mask) << 1;
        for (int d = 1; d < LEVELS; d++) begin
            if (3'(d) <= k_eff) begin
                upd_lv[d] = (r_lv[d-1] & (r_lv[d] | mask)) << 1;
            end
        end
    end

    // match test on the level picked by k
    always_comb begin
        hit = 1'b0;
        for (int d = 0; d < LEVELS; d++) begin
            if (3'(d) == k_eff) begin
                hit = ~upd_lv[d][i_length];
            end
        end
        if (6'(i_length) > 6'(MAX_PATTERN_BYTES)) begin
            hit = 1'b0;
        end
    end

    // start index, clipped at zero and saturated to the field
    assign pos_inc = {1'b0, r_pos} + (PW+1)'(1);
    always_comb begin
        if (pos_inc >= (PW+1)'(i_length)) begin
            start_w = SW'(pos_inc - (PW+1)'(i_length));
        end else begin
            start_w = '0;
        end
    end

    // result and next state
    always_comb begin
        n_lv   = r_lv;
        n_pos  = r_pos;
        n_seen = r_seen;
        o_result.search_status = ST_SEARCHING;
        o_result.match_start   = '0;
        o_result.end_of_text   = i_item.last_byte;

        if (r_seen) begin
            o_result.search_status = ST_MATCHED;
        end else if (i_length == '0) begin
            o_result.search_status = ST_MATCH_NOW;
            n_seen = 1'b1;
        end else begin
            n_lv = upd_lv;
            if (hit) begin
                o_result.search_status = ST_MATCH_NOW;
                o_result.match_start   = (start_w > SW'(16'hFFFF)) ?
                                         16'hFFFF : start_w[15:0];
                n_seen = 1'b1;
            end
            if (r_pos != '1) begin
                n_pos = r_pos + 1'b1;
            end
        end

        if (i_item.last_byte && (o_result.search_status == ST_SEARCHING)) begin
            o_result.search_status = ST_NO_MATCH;
        end

        // last byte puts the text state back to its start
        if (i_item.last_byte) begin
            for (int d = 0; d < LEVELS; d++) begin
                n_lv[d] = VECTOR_INIT;
            end
            n_pos  = '0;
            n_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < LEVELS; d++) begin
                r_lv[d] <= VECTOR_INIT;
            end
            r_pos  <= '0;
            r_seen <= 1'b0;
        end else if (i_accept) begin
            r_lv   <= n_lv;
            r_pos  <= n_pos;
            r_seen <= n_seen;
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bms_pkg::*;

    localparam int MAX_LEVELS   = 7;
    localparam int CYCLE_LIMIT  = 600000;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = REG_PAT_0_7;
    logic [63:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;

    // search model: configuration copy and per-text state
    t_pattern    model_pattern = '0;
    int          model_len     = 0;
    int          model_errors  = 0;
    logic [31:0] rows [LEVEL_SLOTS];
    int          byte_pos;
    bit          text_matched;

    // outcomes predicted for bytes already transferred, oldest first
    t_out_item   search_outcomes [$];
    t_out_item   oldest;
    logic [7:0]  text_buf [$];
    logic [7:0]  byte_pool [4];

    bit          idle_on = 1'b1;
    int          out_hold = 0;
    int          fail_count = 0;
    int          bytes_sent = 0;
    int          live_bytes = 0;
    int          results_checked = 0;
    int          matches_seen = 0;
    int          cycles = 0;

    bitap_mismatch_search_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, search_outcomes.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // back to the start of a text: rows, position and match flag
    function automatic void restart_text_state();
        int d;
        for (d = 0; d < LEVEL_SLOTS; d++)
            rows[d] = VECTOR_INIT;
        byte_pos     = 0;
        text_matched = 1'b0;
    endfunction

    // shift-or step with k substitutions for one text byte
    function automatic t_out_item bitap_step(input logic [7:0] b, input logic last);
        t_out_item   r;
        logic [31:0] mask;
        logic [31:0] prev;
        logic [31:0] held;
        int          i;
        int          d;
        int          k;
        r = '0;
        k = (model_errors > MAX_LEVELS) ? MAX_LEVELS : model_errors;
        if (text_matched) begin
            r.search_status = ST_MATCHED;
        end else if (model_len == 0) begin
            r.search_status = ST_MATCH_NOW;
            text_matched    = 1'b1;
        end else begin
            mask = '1;
            for (i = 0; i < model_len; i++)
                if (model_pattern[i] == b)
                    mask[i] = 1'b0;
            prev    = rows[0];
            rows[0] = (rows[0] | mask) << 1;
            for (d = 1; d <= k; d++) begin
                held    = rows[d];
                rows[d] = (prev & (rows[d] | mask)) << 1;
                prev    = held;
            end
            if (model_len <= MAX_PATTERN_BYTES && !rows[k][model_len]) begin
                r.search_status = ST_MATCH_NOW;
                r.match_start   = (byte_pos + 1 >= model_len) ?
                                  16'(byte_pos + 1 - model_len) : 16'd0;
                text_matched    = 1'b1;
            end
            // position saturates at the top of its range
            if (byte_pos < 16'hFFFF)
                byte_pos++;
        end
        if (last && r.search_status == ST_SEARCHING)
            r.search_status = ST_NO_MATCH;
        r.end_of_text = last;
        if (last)
            restart_text_state();
        return r;
    endfunction

    // one byte transfer, outcome predicted at the accepting edge
    task automatic send_text_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_item.text_byte <= b;
        i_in_item.last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!text_matched)
            live_bytes++;
        bytes_sent++;
        search_outcomes.insert(search_outcomes.size(), bitap_step(b, last));
    endtask

    task automatic send_text_buf();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_text_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    // stop input and let every outstanding result arrive
    task automatic drain();
        i_in_valid <= 1'b0;
        while (search_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // writes all six registers; unused upper data bits carry junk
    task automatic set_search(input t_pattern p, input int len, input int k);
        logic [247:0] flat;
        logic [63:0]  junk;
        flat = p;
        junk = {$urandom, $urandom};
        cfg_write(REG_PAT_0_7,   flat[63:0]);
        cfg_write(REG_PAT_8_15,  flat[127:64]);
        cfg_write(REG_PAT_16_23, flat[191:128]);
        cfg_write(REG_PAT_24_30, {junk[63:56], flat[247:192]});
        cfg_write(REG_PAT_LEN,   {junk[63:5], 5'(len)});
        cfg_write(REG_ERRORS,    {junk[63:3], 3'(k)});
        i_cfg_we      <= 1'b0;
        model_pattern = p;
        model_len     = len;
        model_errors  = k;
    endtask

    // output side: check each transfer and draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (search_outcomes.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding");
                end else begin
                    oldest = search_outcomes.pop_front();
                    results_checked++;
                    if (oldest.search_status == ST_MATCH_NOW)
                        matches_seen++;
                    if (o_out_item.search_status !== oldest.search_status)
                        report_mismatch($sformatf("search_status %0d, want %0d",
                            o_out_item.search_status, oldest.search_status));
                    if (o_out_item.match_start !== oldest.match_start)
                        report_mismatch($sformatf("match_start %0d, want %0d",
                            o_out_item.match_start, oldest.match_start));
                    if (o_out_item.end_of_text !== oldest.end_of_text)
                        report_mismatch($sformatf("end_of_text %0b, want %0b",
                            o_out_item.end_of_text, oldest.end_of_text));
                end
                out_hold = idle_on ? $urandom_range(0, 11) : 0;
            end
            i_out_stall <= (out_hold != 0);
            if (out_hold != 0)
                out_hold--;
        end
    end

    // registers still at reset: empty pattern matches on each text's first byte
    task automatic test_empty_pattern_after_reset();
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b1);
        send_text_byte(8'h80, 1'b1);
        drain();
    endtask

    // exact match, no match, one substitution, errors beyond length
    task automatic test_directed_patterns();
        t_pattern p;
        p    = '0;
        p[0] = 8'h00;
        p[1] = 8'hFF;
        p[2] = 8'h80;
        set_search(p, 3, 0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h80, 1'b1);
        send_text_byte(8'h7F, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h7F, 1'b1);
        drain();
        set_search(p, 3, 1);
        send_text_byte(8'h01, 1'b0);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(8'h81, 1'b0);
        send_text_byte(8'h55, 1'b1);
        drain();
        set_search(p, 1, MAX_LEVELS);
        send_text_byte(8'h42, 1'b1);
        send_text_byte(8'hC3, 1'b0);
        send_text_byte(8'h3C, 1'b1);
        drain();
    endtask

    function automatic logic [7:0] filler_byte();
        if ($urandom_range(0, 9) < 7)
            return byte_pool[$urandom_range(0, 3)];
        return 8'($urandom);
    endfunction

    // mostly planted copies with a few substitutions, the rest noise
    task automatic build_text();
        int mode;
        int n;
        int at;
        int i;
        int subs;
        text_buf.delete();
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
                text_buf.insert(text_buf.size(), 8'($urandom));
        end else if (mode < 4 || model_len == 0) begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
                text_buf.insert(text_buf.size(), filler_byte());
        end else begin
            n  = model_len + $urandom_range(0, 8);
            at = $urandom_range(0, n - model_len);
            for (i = 0; i < n; i++)
                text_buf.insert(text_buf.size(), filler_byte());
            for (i = 0; i < model_len; i++)
                text_buf[at + i] = model_pattern[i];
            subs = $urandom_range(0, model_errors + 1);
            for (i = 0; i < subs; i++)
                text_buf[at + $urandom_range(0, model_len - 1)] = 8'($urandom);
            // a broken copy now and then: cut off before its end
            if ($urandom_range(0, 7) == 0)
                while (text_buf.size() > at + model_len - 1 && text_buf.size() > 1)
                    text_buf.delete(text_buf.size() - 1);
        end
    endtask

    // phases of random settings, extremes first
    task automatic test_random_texts();
        int       phase_len [8] = '{31, 1, 0, 31, 5, -1, -1, -1};
        int       phase_err [8] = '{7, 0, 3, 0, 2, -1, -1, -1};
        t_pattern p;
        int       ph;
        int       i;
        int       len;
        int       k;
        int       start_sent;
        bit       phase_idles;
        for (ph = 0; ph < 8; ph++) begin
            for (i = 0; i < 4; i++)
                byte_pool[i] = 8'($urandom);
            p = '0;
            for (i = 0; i < PATTERN_SLOTS; i++)
                p[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                   : byte_pool[$urandom_range(0, 3)];
            len = (phase_len[ph] < 0) ? $urandom_range(0, 31) : phase_len[ph];
            k   = (phase_err[ph] < 0) ? $urandom_range(0, 7) : phase_err[ph];
            phase_idles = (ph % 3 != 2);
            set_search(p, len, k);
            start_sent = bytes_sent;
            while (bytes_sent - start_sent < 72) begin
                idle_on = phase_idles && ($urandom_range(0, 3) != 0);
                build_text();
                send_text_buf();
            end
            drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        restart_text_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_pattern_after_reset();
        test_directed_patterns();
        test_random_texts();
        drain();
        repeat (4) @(posedge i_clk);
        $display("%0d text bytes sent, %0d searched before a match, %0d results checked",
                 bytes_sent, live_bytes, results_checked);
        $display("%0d matches reported, %0d mismatches", matches_seen, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> bitap_mismatch_search_top.f
sv/bms_pkg.sv
sv/bms_mask.sv
sv/bms_core.sv
sv/bitap_mismatch_search_top.sv
sim/testbench.sv
